[hdl/gbn_pkg.sv]
// Shared types and constants of the Go-Back-N sender window block.
package gbn_pkg;

    localparam int SEQ_MODULO = 16;
    localparam int SEQ_W      = 4;
    localparam int CNT_W      = 5;
    localparam int TIMER_W    = 24;
    localparam int STREAK_W   = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    localparam logic [TIMER_W-1:0]  TIMEOUT_TICKS_RESET = 24'd140;
    localparam logic [STREAK_W-1:0] MAX_STREAK_RESET    = 6'd30;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STREAK    = 1'd1;

    // Event codes on the input channel.
    localparam logic [1:0] OP_SEND = 2'd0;
    localparam logic [1:0] OP_ACK  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // Command kinds handed from the front end to the back end.
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_SEND = 2'd1;
    localparam logic [1:0] KIND_ACK  = 2'd2;
    localparam logic [1:0] KIND_TICK = 2'd3;

    // Result action codes.
    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_SEND    = 2'd1;
    localparam logic [1:0] ACT_RESEND  = 2'd2;
    localparam logic [1:0] ACT_REFUSED = 2'd3;

    typedef struct packed {
        logic [1:0]       kind;
        logic [SEQ_W-1:0] ack_number;
        logic             ack_corrupt;
        logic             ack_completion;
    } t_cmd;

    typedef struct packed {
        logic [1:0]       action;
        logic [SEQ_W-1:0] frame_seq;
        logic             last_of_burst;
        logic [SEQ_W-1:0] window_base;
        logic [CNT_W-1:0] frames_outstanding;
        logic             transfer_done;
        logic             transfer_aborted;
    } t_result;

endpackage

[hdl/gbn_if.sv]
// Channel interfaces: event input, result output and configuration writes.
interface gbn_evt_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  operation;
    logic [gbn_pkg::SEQ_W-1:0]   ack_number;
    logic                        ack_corrupt;
    logic                        ack_completion;

    modport source (output valid, operation, ack_number, ack_corrupt, ack_completion,
                    input ready);
    modport sink   (input valid, operation, ack_number, ack_corrupt, ack_completion,
                    output ready);
endinterface

interface gbn_res_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  action;
    logic [gbn_pkg::SEQ_W-1:0]   frame_seq;
    logic                        last_of_burst;
    logic [gbn_pkg::SEQ_W-1:0]   window_base;
    logic [gbn_pkg::CNT_W-1:0]   frames_outstanding;
    logic                        transfer_done;
    logic                        transfer_aborted;

    modport source (output valid, action, frame_seq, last_of_burst, window_base,
                    frames_outstanding, transfer_done, transfer_aborted,
                    input ready);
    modport sink   (input valid, action, frame_seq, last_of_burst, window_base,
                    frames_outstanding, transfer_done, transfer_aborted,
                    output ready);
endinterface

interface gbn_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [gbn_pkg::CFG_IDX_W-1:0]      index;
    logic [gbn_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hdl/gbn_front.sv]
// Front end: accepts events and classifies them into back-end commands.
module gbn_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    gbn_evt_if.sink         i_evt,
    output logic            o_push_valid,
    input  logic            i_push_ready,
    output gbn_pkg::t_cmd   o_push_cmd
);

    logic          r_valid;
    gbn_pkg::t_cmd r_cmd;
    gbn_pkg::t_cmd w_cmd;
    logic          w_take;

    assign i_evt.ready  = !r_valid || i_push_ready;
    assign w_take       = i_evt.valid && i_evt.ready;
    assign o_push_valid = r_valid;
    assign o_push_cmd   = r_cmd;

    // Acknowledgement fields only travel with acknowledgements.
    always_comb begin
        w_cmd = '0;
        case (i_evt.operation)
            gbn_pkg::OP_SEND: begin
                w_cmd.kind = gbn_pkg::KIND_SEND;
            end
            gbn_pkg::OP_ACK: begin
                w_cmd.kind           = gbn_pkg::KIND_ACK;
                w_cmd.ack_number     = i_evt.ack_number;
                w_cmd.ack_corrupt    = i_evt.ack_corrupt;
                w_cmd.ack_completion = i_evt.ack_completion;
            end
            gbn_pkg::OP_TICK: begin
                w_cmd.kind = gbn_pkg::KIND_TICK;
            end
            default: begin
                w_cmd.kind = gbn_pkg::KIND_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd <= w_cmd;
        end
    end

endmodule

[hdl/gbn_queue.sv]
// Short command queue between the front end and the back end.
module gbn_queue #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  gbn_pkg::t_cmd   i_push_cmd,
    output logic            o_pop_valid,
    input  logic            i_pop,
    output gbn_pkg::t_cmd   o_pop_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH);

    gbn_pkg::t_cmd     r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [FILL_W-1:0] r_fill;
    logic              w_push;
    logic              w_pop;

    assign o_push_ready = (r_fill != FILL_MAX);
    assign o_pop_valid  = (r_fill != '0);
    assign o_pop_cmd    = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (w_pop && !w_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

endmodule

[hdl/gbn_back.sv]
// Back end: window state, purge walk, resend burst and the result register.
module gbn_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [gbn_pkg::TIMER_W-1:0]     i_timeout_ticks,
    input  logic [gbn_pkg::STREAK_W-1:0]    i_max_streak,
    input  logic                            i_cmd_valid,
    input  gbn_pkg::t_cmd                   i_cmd,
    output logic                            o_cmd_pop,
    gbn_res_if.source                       o_res
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ACK   = 2'd1;
    localparam logic [1:0] ST_BURST = 2'd2;

    localparam logic [gbn_pkg::CNT_W-1:0] CNT_FULL = gbn_pkg::CNT_W'(gbn_pkg::SEQ_MODULO);
    localparam logic [gbn_pkg::SEQ_W-1:0] SEQ_LAST =
        gbn_pkg::SEQ_W'(gbn_pkg::SEQ_MODULO - 1);

    logic [1:0]                       r_state, n_state;
    logic [gbn_pkg::SEQ_W-1:0]        r_next_seq, n_next_seq;
    logic [gbn_pkg::SEQ_W-1:0]        r_base, n_base;
    logic [gbn_pkg::CNT_W-1:0]        r_count, n_count;
    logic [gbn_pkg::SEQ_MODULO-1:0]   r_stored, n_stored;
    logic                             r_send_allowed, n_send_allowed;
    logic                             r_still_sending, n_still_sending;
    logic                             r_timer_run, n_timer_run;
    logic [gbn_pkg::TIMER_W-1:0]      r_timer, n_timer;
    logic [gbn_pkg::STREAK_W-1:0]     r_streak, n_streak;
    logic                             r_aborted, n_aborted;
    logic                             r_ack_ok, n_ack_ok;
    logic [gbn_pkg::SEQ_W-1:0]        r_burst_i, n_burst_i;
    logic                             r_out_valid, n_out_valid;
    gbn_pkg::t_result                 r_out, n_out;

    logic                             w_can_emit;
    logic                             w_active;
    logic                             w_emit;
    logic [1:0]                       w_action;
    logic [gbn_pkg::SEQ_W-1:0]        w_seq;
    logic                             w_last;
    logic [gbn_pkg::TIMER_W-1:0]      w_timer_inc;
    logic [gbn_pkg::STREAK_W-1:0]     w_streak_inc;
    logic                             w_purge;

    assign w_can_emit   = !r_out_valid || o_res.ready;
    assign w_active     = r_still_sending && !r_aborted;
    assign w_timer_inc  = (r_timer == '1) ? r_timer : r_timer + 1'b1;
    assign w_streak_inc = (r_streak == '1) ? r_streak : r_streak + 1'b1;
    assign w_purge      = r_ack_ok && (r_base < i_cmd.ack_number) && (r_count != '0);

    always_comb begin
        n_state         = r_state;
        n_next_seq      = r_next_seq;
        n_base          = r_base;
        n_count         = r_count;
        n_stored        = r_stored;
        n_send_allowed  = r_send_allowed;
        n_still_sending = r_still_sending;
        n_timer_run     = r_timer_run;
        n_timer         = r_timer;
        n_streak        = r_streak;
        n_aborted       = r_aborted;
        n_ack_ok        = r_ack_ok;
        n_burst_i       = r_burst_i;
        n_out_valid     = r_out_valid && !o_res.ready;
        n_out           = r_out;
        o_cmd_pop       = 1'b0;
        w_emit          = 1'b0;
        w_action        = gbn_pkg::ACT_NONE;
        w_seq           = '0;
        w_last          = 1'b1;

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.kind)
                        gbn_pkg::KIND_SEND: begin
                            if (w_can_emit) begin
                                w_emit    = 1'b1;
                                o_cmd_pop = 1'b1;
                                if (w_active && r_send_allowed) begin
                                    n_stored[r_next_seq] = 1'b1;
                                    n_next_seq  = r_next_seq + 1'b1;
                                    if (r_count < CNT_FULL) begin
                                        n_count = r_count + 1'b1;
                                    end
                                    n_timer_run = 1'b1;
                                    n_timer     = '0;
                                    // A batch ends when the sequence number wraps.
                                    if (r_next_seq == SEQ_LAST) begin
                                        n_send_allowed = 1'b0;
                                    end
                                    n_streak = '0;
                                    w_action = gbn_pkg::ACT_SEND;
                                    w_seq    = r_next_seq;
                                end else begin
                                    w_action = gbn_pkg::ACT_REFUSED;
                                end
                            end
                        end
                        gbn_pkg::KIND_ACK: begin
                            if (w_active) begin
                                n_streak = '0;
                                n_ack_ok = !i_cmd.ack_corrupt &&
                                           ({1'b0, i_cmd.ack_number} <= r_count);
                            end else begin
                                n_ack_ok = 1'b0;
                            end
                            n_state = ST_ACK;
                        end
                        gbn_pkg::KIND_TICK: begin
                            n_ack_ok = 1'b0;
                            n_state  = ST_ACK;
                            if (w_active && r_timer_run) begin
                                n_timer = w_timer_inc;
                                if (w_timer_inc >= i_timeout_ticks) begin
                                    n_timer   = '0;
                                    n_streak  = w_streak_inc;
                                    if (w_streak_inc > i_max_streak) begin
                                        n_aborted = 1'b1;
                                    end
                                    n_burst_i = '0;
                                    n_state   = ST_BURST;
                                end
                            end
                        end
                        default: begin
                            n_ack_ok = 1'b0;
                            n_state  = ST_ACK;
                        end
                    endcase
                end
            end

            // Walks the purge one slot per cycle, then gives the single plain result.
            // Events that need no more than a plain result pass through here too.
            ST_ACK: begin
                if (w_purge) begin
                    n_stored[r_base] = 1'b0;
                    n_base      = r_base + 1'b1;
                    n_count     = r_count - 1'b1;
                    n_timer_run = 1'b0;
                end else if (w_can_emit) begin
                    if (r_ack_ok) begin
                        if ((i_cmd.ack_number == '0) && !r_stored[0]) begin
                            n_send_allowed = 1'b1;
                            n_base         = r_next_seq;
                            n_count        = '0;
                            n_stored       = '0;
                        end
                        if (i_cmd.ack_completion) begin
                            n_still_sending = 1'b0;
                        end
                    end
                    w_emit    = 1'b1;
                    o_cmd_pop = 1'b1;
                    n_state   = ST_IDLE;
                end
            end

            ST_BURST: begin
                if (w_can_emit) begin
                    w_emit = 1'b1;
                    if (r_count == '0) begin
                        o_cmd_pop = 1'b1;
                        n_state   = ST_IDLE;
                    end else begin
                        w_action  = gbn_pkg::ACT_RESEND;
                        w_seq     = r_base + r_burst_i;
                        w_last    = ({1'b0, r_burst_i} == r_count - 1'b1);
                        n_burst_i = r_burst_i + 1'b1;
                        if (w_last) begin
                            o_cmd_pop = 1'b1;
                            n_state   = ST_IDLE;
                        end
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Every result reports the window as it stands after its event.
        if (w_emit) begin
            n_out_valid              = 1'b1;
            n_out.action             = w_action;
            n_out.frame_seq          = w_seq;
            n_out.last_of_burst      = w_last;
            n_out.window_base        = n_base;
            n_out.frames_outstanding = n_count;
            n_out.transfer_done      = !n_still_sending;
            n_out.transfer_aborted   = n_aborted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_next_seq      <= '0;
            r_base          <= '0;
            r_count         <= '0;
            r_stored        <= '0;
            r_send_allowed  <= 1'b1;
            r_still_sending <= 1'b1;
            r_timer_run     <= 1'b0;
            r_timer         <= '0;
            r_streak        <= '0;
            r_aborted       <= 1'b0;
            r_ack_ok        <= 1'b0;
            r_burst_i       <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_next_seq      <= n_next_seq;
            r_base          <= n_base;
            r_count         <= n_count;
            r_stored        <= n_stored;
            r_send_allowed  <= n_send_allowed;
            r_still_sending <= n_still_sending;
            r_timer_run     <= n_timer_run;
            r_timer         <= n_timer;
            r_streak        <= n_streak;
            r_aborted       <= n_aborted;
            r_ack_ok        <= n_ack_ok;
            r_burst_i       <= n_burst_i;
            r_out_valid     <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_res.valid              = r_out_valid;
    assign o_res.action             = r_out.action;
    assign o_res.frame_seq          = r_out.frame_seq;
    assign o_res.last_of_burst      = r_out.last_of_burst;
    assign o_res.window_base        = r_out.window_base;
    assign o_res.frames_outstanding = r_out.frames_outstanding;
    assign o_res.transfer_done      = r_out.transfer_done;
    assign o_res.transfer_aborted   = r_out.transfer_aborted;

endmodule

[hdl/go_back_n_sender_window.sv]
// Go-Back-N sender window control with 4-bit sequence numbers. Events (send request,
// acknowledgement, time tick) enter through a registered front end and a short command
// queue, so new events are taken while the back end works or a result waits. The back
// end handles one event at a time: a send request is answered straight from idle, a tick
// without timeout or an acknowledgement passes through the acknowledgement state, which
// first purges each acknowledged slot and then gives a plain result, and a timeout
// resends each outstanding frame (up to 16), or gives one plain result when nothing is
// outstanding. The purge walk and the resend burst, one slot per cycle in the back end
// (the burst only while results are taken), set the rate. Every event yields at least
// one result, and the last result of an event carries last_of_burst.
module go_back_n_sender_window #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gbn_cfg_if.sink     i_cfg,
    gbn_evt_if.sink     i_evt,
    gbn_res_if.source   o_res
);

    logic [gbn_pkg::TIMER_W-1:0]  r_timeout_ticks;
    logic [gbn_pkg::STREAK_W-1:0] r_max_streak;

    logic          w_push_valid;
    logic          w_push_ready;
    gbn_pkg::t_cmd w_push_cmd;
    logic          w_pop_valid;
    logic          w_pop;
    gbn_pkg::t_cmd w_pop_cmd;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ticks <= gbn_pkg::TIMEOUT_TICKS_RESET;
            r_max_streak    <= gbn_pkg::MAX_STREAK_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                gbn_pkg::REG_TIMEOUT_TICKS: begin
                    r_timeout_ticks <= i_cfg.data;
                end
                gbn_pkg::REG_MAX_STREAK: begin
                    r_max_streak <= i_cfg.data[gbn_pkg::STREAK_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    gbn_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_evt        (i_evt),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_cmd   (w_push_cmd)
    );

    gbn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_cmd   (w_push_cmd),
        .o_pop_valid  (w_pop_valid),
        .i_pop        (w_pop),
        .o_pop_cmd    (w_pop_cmd)
    );

    gbn_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_timeout_ticks (r_timeout_ticks),
        .i_max_streak    (r_max_streak),
        .i_cmd_valid     (w_pop_valid),
        .i_cmd           (w_pop_cmd),
        .o_cmd_pop       (w_pop),
        .o_res           (o_res)
    );

endmodule

[hdl/gbn_checker.sv]
// Port-level checks on the result channel, bound to the top level.
module gbn_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       i_ready,
    input logic [1:0]                 i_action,
    input logic [gbn_pkg::SEQ_W-1:0]  i_frame_seq,
    input logic                       i_last,
    input logic [gbn_pkg::CNT_W-1:0]  i_count
);

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_action) && $stable(i_frame_seq)
                                && $stable(i_last) && $stable(i_count))
        else $error("result changed while stalled");

    // Nothing is presented in the cycle after reset is released.
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_valid)
        else $error("result valid right after reset");

    // A resend only happens with frames outstanding.
    a_resend_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_action == gbn_pkg::ACT_RESEND) |-> (i_count != '0))
        else $error("resend with empty window");

    // Only a resend burst spans several results.
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && ((i_action == gbn_pkg::ACT_SEND) || (i_action == gbn_pkg::ACT_REFUSED)
                    || (i_action == gbn_pkg::ACT_NONE)) |-> i_last)
        else $error("non-resend result not marked last");

endmodule

bind go_back_n_sender_window gbn_checker u_gbn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_res.valid),
    .i_ready     (o_res.ready),
    .i_action    (o_res.action),
    .i_frame_seq (o_res.frame_seq),
    .i_last      (o_res.last_of_burst),
    .i_count     (o_res.frames_outstanding)
);
